/* src/lcdtg_pkg.sv */
`timescale 1ns / 1ps

package lcdtg_pkg;

    // Memory sizes and bases in the CPU address map
    localparam int VIDEO_BYTES = 8192;
    localparam int ATTR_BYTES  = 160;
    localparam int VIDEO_AW    = $clog2(VIDEO_BYTES);
    localparam int ATTR_AW     = $clog2(ATTR_BYTES);
    localparam logic [15:0] VIDEO_BASE = 16'h8000;
    localparam logic [15:0] ATTR_BASE  = 16'hFE00;
    localparam logic [7:0]  BLOCKED_BYTE = 8'hFF;

    // Line and frame timing
    localparam int VISIBLE_LINES = 144;
    localparam int TOTAL_LINES   = 154;
    localparam int DOTS_PER_LINE = 456;
    localparam int SCAN_DOTS     = 80;
    localparam int DRAW_DOTS     = 200;
    localparam int DRAW_END      = (SCAN_DOTS + DRAW_DOTS >= DOTS_PER_LINE) ?
                                   DOTS_PER_LINE - 1 : SCAN_DOTS + DRAW_DOTS;

    // Display modes
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_SCAN   = 2'd2;
    localparam logic [1:0] MODE_DRAW   = 2'd3;

    // Commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Access status
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_BLOCKED  = 2'd1;
    localparam logic [1:0] ST_UNMAPPED = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PPU_ENABLE     = 2'd0;
    localparam logic [1:0] CFG_LINE_COMPARE   = 2'd1;
    localparam logic [1:0] CFG_STAT_SELECT    = 2'd2;
    localparam logic [1:0] CFG_LCD_IRQ_ENABLE = 2'd3;

    // STAT source bits in stat_select
    localparam int SRC_HBLANK = 0;
    localparam int SRC_VBLANK = 1;
    localparam int SRC_SCAN   = 2;
    localparam int SRC_MATCH  = 3;

    typedef struct packed {
        logic       ppu_enable;
        logic [7:0] line_compare;
        logic [3:0] stat_select;
        logic       lcd_irq_enable;
    } lcdtg_cfg_t;

    // Timing view after one item
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] line;
        logic       line_match;
        logic       vblank_irq;
        logic       stat_irq;
    } lcdtg_view_t;

endpackage

/* src/lcdtg_ram.sv */
`timescale 1ns / 1ps

module lcdtg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port: write or registered read, read data held until the next read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/lcdtg_timing.sv */
`timescale 1ns / 1ps

module lcdtg_timing (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     tick,
    input  lcdtg_pkg::lcdtg_cfg_t    cfg,
    output logic [1:0]               mode_now,
    output lcdtg_pkg::lcdtg_view_t   view
);
    import lcdtg_pkg::*;

    logic [8:0] dot_reg,   dot_next;
    logic [7:0] line_reg,  line_next;
    logic [1:0] mode_reg,  mode_next;
    logic       match_reg, match_next;
    logic       prev_reg,  prev_next;
    logic [8:0] dot_inc;
    logic [8:0] line_inc;
    logic       src;
    logic       vblank;
    logic [3:0] src_on;

    assign src_on = cfg.lcd_irq_enable ? cfg.stat_select : 4'd0;

    // Advance dot, mode and line on an enabled tick
    always_comb begin
        dot_inc    = dot_reg + 9'd1;
        line_inc   = {1'b0, line_reg} + 9'd1;
        dot_next   = dot_reg;
        line_next  = line_reg;
        mode_next  = mode_reg;
        match_next = match_reg;
        prev_next  = prev_reg;
        src        = 1'b0;
        vblank     = 1'b0;
        if (tick) begin
            dot_next = dot_inc;
            case (mode_reg)
                MODE_SCAN: begin
                    if (dot_inc >= 9'(SCAN_DOTS)) begin
                        mode_next = MODE_DRAW;
                    end
                end
                MODE_DRAW: begin
                    if (dot_inc >= 9'(DRAW_END)) begin
                        mode_next = MODE_HBLANK;
                        src       = src_on[SRC_HBLANK];
                    end
                end
                default: begin
                    if (dot_inc >= 9'(DOTS_PER_LINE)) begin
                        dot_next = 9'd0;
                        if (mode_reg == MODE_HBLANK && line_inc == 9'(VISIBLE_LINES)
                            && line_inc < 9'(TOTAL_LINES)) begin
                            mode_next = MODE_VBLANK;
                            vblank    = 1'b1;
                            src       = src_on[SRC_VBLANK];
                            line_next = line_inc[7:0];
                        end else if (mode_reg == MODE_HBLANK
                                     || line_inc >= 9'(TOTAL_LINES)) begin
                            mode_next = MODE_SCAN;
                            src       = src_on[SRC_SCAN];
                            line_next = (line_inc >= 9'(TOTAL_LINES)) ? 8'd0 : line_inc[7:0];
                        end else begin
                            line_next = line_inc[7:0];
                        end
                        match_next = (line_next == cfg.line_compare);
                        if (match_next && src_on[SRC_MATCH]) begin
                            src = 1'b1;
                        end
                    end
                end
            endcase
            prev_next = src;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg   <= 9'd0;
            line_reg  <= 8'd0;
            mode_reg  <= MODE_HBLANK;
            match_reg <= 1'b0;
            prev_reg  <= 1'b0;
        end else begin
            dot_reg   <= dot_next;
            line_reg  <= line_next;
            mode_reg  <= mode_next;
            match_reg <= match_next;
            prev_reg  <= prev_next;
        end
    end

    assign mode_now        = mode_reg;
    assign view.mode       = mode_next;
    assign view.line       = line_next;
    assign view.line_match = match_next;
    assign view.vblank_irq = vblank;
    assign view.stat_irq   = tick && src && !prev_reg;

endmodule

/* src/lcd_timing_and_vram_gate_unit.sv */
`timescale 1ns / 1ps
// Pipeline: an input transfer passes the registered RAM read and then the output
// register before its result appears; m_tready back-pressure can stall both.
// Throughput: one item per cycle unless stalled, set by each RAM's single port.
// Reset: synchronous, active low; clears timing counters, configuration and valid
// flags. Video and attribute memories are not cleared and hold undefined data.
module lcd_timing_and_vram_gate_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // command [1:0], address [17:2], write_data [25:18], zero [31:26]
    input  logic [31:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // read_data [7:0], access_status [9:8], mode [11:10], current_line [19:12],
    // line_match [20], vblank_irq [21], stat_irq [22], zero [23]
    output logic [23:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);
    import lcdtg_pkg::*;

    lcdtg_cfg_t  cfg_reg;
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        accept;
    logic        advance;
    logic [1:0]  mode_now;
    lcdtg_view_t view;
    logic [16:0] vid_off;
    logic [16:0] attr_off;
    logic        vid_hit;
    logic        attr_hit;
    logic        open;
    logic        is_rw;
    logic [1:0]  status;
    logic        vid_rdata_sel;
    logic [7:0]  vid_rdata;
    logic [7:0]  attr_rdata;
    logic [7:0]  rdata;

    // Stage after the RAM read
    logic        s1_valid_reg;
    logic        s1_read_reg;
    logic        s1_attr_reg;
    logic [1:0]  s1_status_reg;
    lcdtg_view_t s1_view_reg;

    logic        m_valid_reg;
    logic [23:0] m_data_reg;

    assign cmd   = s_tdata[1:0];
    assign addr  = s_tdata[17:2];
    assign wdata = s_tdata[25:18];

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PPU_ENABLE:     cfg_reg.ppu_enable     <= cfg_wdata[0];
                CFG_LINE_COMPARE:   cfg_reg.line_compare   <= cfg_wdata;
                CFG_STAT_SELECT:    cfg_reg.stat_select    <= cfg_wdata[3:0];
                CFG_LCD_IRQ_ENABLE: cfg_reg.lcd_irq_enable <= cfg_wdata[0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    lcdtg_timing u_timing (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tick     (accept && cmd == CMD_TICK && cfg_reg.ppu_enable),
        .cfg      (cfg_reg),
        .mode_now (mode_now),
        .view     (view)
    );

    // Decode the address and gate access by the current mode
    assign vid_off  = {1'b0, addr} - {1'b0, VIDEO_BASE};
    assign attr_off = {1'b0, addr} - {1'b0, ATTR_BASE};
    assign vid_hit  = addr >= VIDEO_BASE && vid_off < 17'(VIDEO_BYTES);
    assign attr_hit = addr >= ATTR_BASE && attr_off < 17'(ATTR_BYTES);
    assign is_rw    = cmd == CMD_READ || cmd == CMD_WRITE;

    always_comb begin
        if (vid_hit) begin
            open = !cfg_reg.ppu_enable || mode_now != MODE_DRAW;
        end else begin
            open = !cfg_reg.ppu_enable || mode_now == MODE_HBLANK
                   || mode_now == MODE_VBLANK;
        end
        if (!is_rw) begin
            status = ST_DONE;
        end else if (!vid_hit && !attr_hit) begin
            status = ST_UNMAPPED;
        end else if (!open) begin
            status = ST_BLOCKED;
        end else begin
            status = ST_DONE;
        end
    end

    lcdtg_ram #(
        .WIDTH (8),
        .DEPTH (VIDEO_BYTES)
    ) u_video_ram (
        .aclk  (aclk),
        .we    (accept && cmd == CMD_WRITE && vid_hit && open),
        .re    (accept && cmd == CMD_READ && vid_hit && open),
        .addr  (vid_off[VIDEO_AW-1:0]),
        .wdata (wdata),
        .rdata (vid_rdata)
    );

    lcdtg_ram #(
        .WIDTH (8),
        .DEPTH (ATTR_BYTES)
    ) u_attr_ram (
        .aclk  (aclk),
        .we    (accept && cmd == CMD_WRITE && attr_hit && open),
        .re    (accept && cmd == CMD_READ && attr_hit && open),
        .addr  (attr_off[ATTR_AW-1:0]),
        .wdata (wdata),
        .rdata (attr_rdata)
    );

    // Hold item details while the RAM read completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_read_reg   <= cmd == CMD_READ;
            s1_attr_reg   <= !vid_hit;
            s1_status_reg <= status;
            s1_view_reg   <= view;
        end
    end

    // Select the read byte
    assign vid_rdata_sel = !s1_attr_reg;
    always_comb begin
        if (!s1_read_reg) begin
            rdata = 8'd0;
        end else if (s1_status_reg != ST_DONE) begin
            rdata = BLOCKED_BYTE;
        end else if (vid_rdata_sel) begin
            rdata = vid_rdata;
        end else begin
            rdata = attr_rdata;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_valid_reg) begin
            m_data_reg <= {1'b0, s1_view_reg.stat_irq, s1_view_reg.vblank_irq,
                           s1_view_reg.line_match, s1_view_reg.line, s1_view_reg.mode,
                           s1_status_reg, rdata};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
